/* design/cpr_pkg.sv */
// Package with the shared constants and types of the clock page replacement block.
package cpr_pkg;

    localparam int MAX_CELLS = 64;
    localparam int PAGES     = 128;

    localparam int PAGE_W  = 7;
    localparam int CFG_W   = 7;
    localparam int RES_W   = 7;
    localparam int FAULT_W = 16;

    localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W  = $clog2(MAX_CELLS + 2);
    localparam int PIDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [CELL_W-1:0]  t_cell_idx;
    typedef logic [CNT_W-1:0]   t_cell_num;
    typedef logic [FAULT_W-1:0] t_fault;

endpackage

/* design/cpr_in_if.sv */
// Input channel interface carrying one page access per transfer.
interface cpr_in_if
    import cpr_pkg::*;
();
    logic  valid;
    logic  ready;
    t_page page;
    logic  restart;

    modport source (output valid, output page, output restart, input ready);
    modport sink (input valid, input page, input restart, output ready);
endinterface

/* design/cpr_out_if.sv */
// Output channel interface carrying one replacement result per transfer.
interface cpr_out_if
    import cpr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [RES_W-1:0] cell_res;
    t_fault           fault_total;

    modport source (output valid, output hit, output cell_res, output fault_total, input ready);
    modport sink (input valid, input hit, input cell_res, input fault_total, output ready);
endinterface

/* design/cpr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/clock_page_replacement.sv */
// Clock (second-chance) page replacement with page map and cell table held in RAM.
// Each transfer on the input channel is one page access and yields one result. A hit or a
// miss that fills a free cell first reads the page map RAM, then decides and writes back.
// A miss after all cells are filled then sweeps the hand through the cell table RAM, at
// most cells_in_use plus one visits, since that RAM gives one entry per cycle. Page map
// presence is kept in flip-flops that reset and restart clear at once, so there is no
// clearing pass. A finished result waits in an output register.
module clock_page_replacement
    import cpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    cpr_in_if.sink             i_in,
    cpr_out_if.source          o_out
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    localparam t_cell_num ONE_CELL = t_cell_num'(1);

    logic [1:0]       r_state, n_state;
    t_page            r_page, n_page;
    t_cell_num        r_hand, n_hand;
    t_cell_num        r_fill, n_fill;
    t_fault           r_fault, n_fault;
    logic [PAGES-1:0] r_valid, n_valid;
    logic [CFG_W-1:0] r_cells;
    logic             r_fwd;

    logic             r_o_valid, n_o_valid;
    logic             r_o_hit, n_o_hit;
    t_cell_num        r_o_cell, n_o_cell;
    t_fault           r_o_fault, n_o_fault;
    logic             r_p_hit, n_p_hit;
    t_cell_num        r_p_cell, n_p_cell;
    t_fault           r_p_fault, n_p_fault;

    t_cell_num        w_n;
    t_fault           w_fault_inc;
    logic             w_fin;
    logic             w_res_hit;
    t_cell_num        w_res_cell;
    logic             w_out_free;

    logic             w_cwe;
    t_cell_idx        w_cwaddr;
    logic [PAGE_W:0]  w_cwdata;
    t_cell_idx        w_craddr;
    logic [PAGE_W:0]  w_crdata;
    logic             w_ref;

    logic             w_pwe;
    t_cell_idx        w_prdata;
    t_cell_num        w_map_cell;

    cpr_ram #(.WIDTH(CELL_W), .DEPTH(PAGES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (r_page[PIDX_W-1:0]),
        .i_wdata (w_res_cell[CELL_W-1:0] - CELL_W'(1)),
        .i_raddr (i_in.page[PIDX_W-1:0]),
        .o_rdata (w_prdata)
    );

    cpr_ram #(.WIDTH(PAGE_W + 1), .DEPTH(MAX_CELLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_cwaddr),
        .i_wdata (w_cwdata),
        .i_raddr (w_craddr),
        .o_rdata (w_crdata)
    );

    function automatic t_cell_num next_cell(t_cell_num c, t_cell_num n);
        return (c >= n) ? ONE_CELL : c + ONE_CELL;
    endfunction

    function automatic t_cell_idx cell_idx(t_cell_num c);
        t_cell_num d;
        d = c - ONE_CELL;
        return d[CELL_W-1:0];
    endfunction

    always_comb begin
        if (r_cells == '0) begin
            w_n = ONE_CELL;
        end else if ({1'b0, r_cells} > (CFG_W + 1)'(MAX_CELLS)) begin
            w_n = t_cell_num'(MAX_CELLS);
        end else begin
            w_n = t_cell_num'(r_cells);
        end
    end

    assign w_fault_inc = (&r_fault) ? r_fault : r_fault + t_fault'(1);
    assign w_map_cell  = t_cell_num'(w_prdata) + ONE_CELL;
    assign w_ref       = w_crdata[0] & ~r_fwd;
    assign w_craddr    = cell_idx(n_hand);
    assign w_out_free  = !r_o_valid || o_out.ready;

    always_comb begin
        n_state   = r_state;
        n_page    = r_page;
        n_hand    = r_hand;
        n_fill    = r_fill;
        n_fault   = r_fault;
        n_valid   = r_valid;
        w_fin     = 1'b0;
        w_res_hit = 1'b0;
        w_res_cell = r_hand;
        w_cwe     = 1'b0;
        w_cwaddr  = cell_idx(r_hand);
        w_cwdata  = {r_page, 1'b1};
        w_pwe     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_page  = i_in.page;
                    n_state = S_LOOK;
                    if (i_in.restart) begin
                        n_valid = '0;
                        n_hand  = ONE_CELL;
                        n_fill  = ONE_CELL;
                        n_fault = '0;
                    end
                end
            end
            S_LOOK: begin
                if (r_valid[r_page[PIDX_W-1:0]]) begin
                    w_fin      = 1'b1;
                    w_res_hit  = 1'b1;
                    w_res_cell = w_map_cell;
                    w_cwe      = 1'b1;
                    w_cwaddr   = cell_idx(w_map_cell);
                end else begin
                    n_fault = w_fault_inc;
                    if (r_fill <= w_n) begin
                        w_fin      = 1'b1;
                        w_res_cell = r_fill;
                        w_cwe      = 1'b1;
                        w_cwaddr   = cell_idx(r_fill);
                        w_pwe      = 1'b1;
                        n_valid[r_page[PIDX_W-1:0]] = 1'b1;
                        n_fill     = r_fill + ONE_CELL;
                    end else begin
                        if (r_hand > w_n) begin
                            n_hand = ONE_CELL;
                        end
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                if (w_ref) begin
                    w_cwe    = 1'b1;
                    w_cwdata = {w_crdata[PAGE_W:1], 1'b0};
                    n_hand   = next_cell(r_hand, w_n);
                end else begin
                    n_valid[w_crdata[PIDX_W:1]] = 1'b0;
                    n_valid[r_page[PIDX_W-1:0]] = 1'b1;
                    w_fin    = 1'b1;
                    w_cwe    = 1'b1;
                    w_pwe    = 1'b1;
                    n_hand   = next_cell(r_hand, w_n);
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            n_state = w_out_free ? S_IDLE : S_HOLD;
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_hit   = r_o_hit;
        n_o_cell  = r_o_cell;
        n_o_fault = r_o_fault;
        n_p_hit   = r_p_hit;
        n_p_cell  = r_p_cell;
        n_p_fault = r_p_fault;
        if (o_out.ready) begin
            n_o_valid = 1'b0;
        end
        if (w_fin) begin
            if (w_out_free) begin
                n_o_valid = 1'b1;
                n_o_hit   = w_res_hit;
                n_o_cell  = w_res_cell;
                n_o_fault = n_fault;
            end else begin
                n_p_hit   = w_res_hit;
                n_p_cell  = w_res_cell;
                n_p_fault = n_fault;
            end
        end else if (r_state == S_HOLD && w_out_free) begin
            n_o_valid = 1'b1;
            n_o_hit   = r_p_hit;
            n_o_cell  = r_p_cell;
            n_o_fault = r_p_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hand    <= ONE_CELL;
            r_fill    <= ONE_CELL;
            r_fault   <= '0;
            r_valid   <= '0;
            r_cells   <= CFG_W'(MAX_CELLS);
            r_o_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hand    <= n_hand;
            r_fill    <= n_fill;
            r_fault   <= n_fault;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
            r_fwd     <= w_cwe && (w_cwaddr == w_craddr);
            if (i_cfg_we) begin
                r_cells <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page    <= n_page;
        r_o_hit   <= n_o_hit;
        r_o_cell  <= n_o_cell;
        r_o_fault <= n_o_fault;
        r_p_hit   <= n_p_hit;
        r_p_cell  <= n_p_cell;
        r_p_fault <= n_p_fault;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_o_valid;
    assign o_out.hit         = r_o_hit;
    assign o_out.cell_res    = RES_W'(r_o_cell);
    assign o_out.fault_total = r_o_fault;
endmodule

/* design/cpr_checker.sv */
// Port-level checker for the clock page replacement block, with its bind statement.
module cpr_checker
    import cpr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_hit,
    input logic [RES_W-1:0] i_out_cell,
    input t_fault           i_out_fault
);
    logic [1:0] r_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 2'(i_in_valid && i_in_ready) - 2'(i_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cell)
            && $stable(i_out_hit) && $stable(i_out_fault))
        else $error("Output changed while a transfer was stalled.");

    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_cell != '0 && i_out_cell <= RES_W'(MAX_CELLS))
        else $error("Reported cell is outside the managed range.");

    a_one_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= 2'd2 && (!i_out_valid || r_open != 2'd0))
        else $error("Results do not match accepted accesses one for one.");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Input accepted again while an access was still being handled.");
endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hit   (o_out.hit),
    .i_out_cell  (o_out.cell_res),
    .i_out_fault (o_out.fault_total)
);

/* dv/tb_clock_page_replacement.sv */
// Self-checking testbench for the clock page replacement block, table-driven and random.
`timescale 1ns / 1ps

module tb_clock_page_replacement;
    import cpr_pkg::*;

    typedef enum logic {
        ROW_ACCESS,
        ROW_CELLS
    } t_row_kind;

    typedef struct packed {
        logic             hit;
        logic [RES_W-1:0] slot;
        t_fault           faults;
    } t_access_res;

    typedef struct {
        t_row_kind        kind;
        logic [CFG_W-1:0] val;
        logic             rs;
        logic             typed;
        t_access_res      want;
    } t_dir_row;

    localparam t_access_res NO_TYPED = '0;
    localparam int N_DIR          = 26;
    localparam int N_PHASES       = 12;
    localparam int PHASE_ITEMS    = 82;
    localparam int ONE_CELL_ITEMS = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_PRINTS     = 100;

    localparam logic [CFG_W-1:0] PHASE_CELLS [10] = '{
        7'd2, 7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd3, 7'd16, 7'd5, 7'd40
    };

    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_ACCESS, 7'd0,   1'b0, 1'b1, '{1'b0, 7'd1, 16'd1}},
        '{ROW_ACCESS, 7'd127, 1'b0, 1'b1, '{1'b0, 7'd2, 16'd2}},
        '{ROW_ACCESS, 7'd0,   1'b0, 1'b1, '{1'b1, 7'd1, 16'd2}},
        '{ROW_ACCESS, 7'd127, 1'b1, 1'b1, '{1'b0, 7'd1, 16'd1}},
        '{ROW_CELLS,  7'd1,   1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd5,   1'b0, 1'b1, '{1'b0, 7'd1, 16'd2}},
        '{ROW_ACCESS, 7'd5,   1'b0, 1'b1, '{1'b1, 7'd1, 16'd2}},
        '{ROW_CELLS,  7'd0,   1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd6,   1'b0, 1'b1, '{1'b0, 7'd1, 16'd3}},
        '{ROW_CELLS,  7'd127, 1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd7,   1'b0, 1'b1, '{1'b0, 7'd2, 16'd4}},
        '{ROW_ACCESS, 7'd6,   1'b0, 1'b1, '{1'b1, 7'd1, 16'd4}},
        '{ROW_CELLS,  7'd65,  1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd8,   1'b0, 1'b1, '{1'b0, 7'd3, 16'd5}},
        '{ROW_CELLS,  7'd2,   1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd9,   1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd8,   1'b0, 1'b0, NO_TYPED},
        '{ROW_CELLS,  7'd5,   1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd10,  1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd11,  1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd12,  1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd85,  1'b0, 1'b0, NO_TYPED},
        '{ROW_CELLS,  7'd2,   1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd42,  1'b0, 1'b0, NO_TYPED},
        '{ROW_ACCESS, 7'd12,  1'b1, 1'b1, '{1'b0, 7'd1, 16'd1}},
        '{ROW_ACCESS, 7'd127, 1'b0, 1'b0, NO_TYPED}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    cpr_in_if  in_ch ();
    cpr_out_if out_ch ();

    clock_page_replacement u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow of the replacement state.
    logic [RES_W-1:0] frame_of_page [PAGES];
    t_page            page_of_frame [1:MAX_CELLS];
    bit               second_chance [1:MAX_CELLS];
    int unsigned      hand_pos;
    int unsigned      next_free;
    t_fault           faults_seen;
    logic [CFG_W-1:0] frames_cfg;

    t_access_res awaited_results [$];
    logic        cur_typed;
    t_access_res cur_typed_res;
    bit          no_gaps;
    bit          squeeze;
    bit          hold_off;
    int          n_err;
    int          stall_cycles;

    always #5 i_clk = ~i_clk;

    function automatic t_access_res replace_page(input t_page pg, input logic rs);
        int unsigned n;
        int unsigned c;
        t_access_res r;
        n = frames_cfg;
        if (n < 1) n = 1;
        if (n > MAX_CELLS) n = MAX_CELLS;
        if (rs) begin
            foreach (frame_of_page[i]) frame_of_page[i] = '0;
            hand_pos    = 1;
            next_free   = 1;
            faults_seen = '0;
        end
        c = frame_of_page[pg];
        if (c >= 1 && c <= MAX_CELLS) begin
            second_chance[c] = 1'b1;
            r.hit = 1'b1;
        end else begin
            if (faults_seen != 16'hFFFF) faults_seen = faults_seen + 1'b1;
            if (next_free >= 1 && next_free <= n) begin
                c = next_free;
                next_free = next_free + 1;
            end else begin
                if (hand_pos < 1 || hand_pos > n) hand_pos = 1;
                while (second_chance[hand_pos]) begin
                    second_chance[hand_pos] = 1'b0;
                    hand_pos = (hand_pos >= n) ? 1 : hand_pos + 1;
                end
                c = hand_pos;
                frame_of_page[page_of_frame[c]] = '0;
                hand_pos = (hand_pos >= n) ? 1 : hand_pos + 1;
            end
            page_of_frame[c] = pg;
            second_chance[c] = 1'b1;
            frame_of_page[pg] = RES_W'(c);
            r.hit = 1'b0;
        end
        r.slot   = RES_W'(c);
        r.faults = faults_seen;
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        n_err = n_err + 1;
        if (n_err <= MAX_PRINTS) begin
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        end
    endtask

    task automatic offer_access(input t_page pg, input logic rs, input logic typed,
                                input t_access_res tres);
        while (!no_gaps && $urandom_range(99) < 24) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.page    = pg;
        in_ch.restart = rs;
        cur_typed     = typed;
        cur_typed_res = tres;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cells(input logic [CFG_W-1:0] v);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        frames_cfg  = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = !hold_off && (no_gaps || $urandom_range(99) >= 24);
        end
    end

    // The receiver stops taking results for a long stretch while the sender keeps offering.
    initial begin
        hold_off = 1'b0;
        wait (squeeze);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin : scoreboard
        t_access_res r;
        t_access_res w;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                r = replace_page(in_ch.page, in_ch.restart);
                if (cur_typed) r = cur_typed_res;
                awaited_results.push_back(r);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    report("unexpected result, cell", out_ch.cell_res, 0);
                end else begin
                    w = awaited_results.pop_front();
                    if (out_ch.hit !== w.hit) report("hit", out_ch.hit, w.hit);
                    if (out_ch.cell_res !== w.slot) report("cell_res", out_ch.cell_res, w.slot);
                    if (out_ch.fault_total !== w.faults) begin
                        report("fault_total", out_ch.fault_total, w.faults);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_clock_page_replacement: errors");
            $finish;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
    end

    initial begin
        int               ph;
        int               k;
        int               roll;
        int unsigned      eff;
        int unsigned      ws;
        logic [CFG_W-1:0] cv;
        t_page            base;
        t_page            pg;
        t_page            prev_pg;
        logic             rs;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_ch.valid   = 1'b0;
        in_ch.page    = '0;
        in_ch.restart = 1'b0;
        cur_typed     = 1'b0;
        cur_typed_res = NO_TYPED;
        no_gaps       = 1'b0;
        squeeze       = 1'b0;
        n_err         = 0;
        stall_cycles  = 0;

        frames_cfg  = 7'd64;
        hand_pos    = 1;
        next_free   = 1;
        faults_seen = '0;
        foreach (frame_of_page[i]) frame_of_page[i] = '0;
        foreach (page_of_frame[i]) page_of_frame[i] = '0;
        foreach (second_chance[i]) second_chance[i] = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < N_DIR; k++) begin
            if (dir_rows[k].kind == ROW_CELLS) begin
                settle();
                write_cells(dir_rows[k].val);
            end else begin
                offer_access(dir_rows[k].val, dir_rows[k].rs, dir_rows[k].typed,
                             dir_rows[k].want);
            end
        end

        // Traffic mostly stays inside a moving working set, so hits and sweeps both occur.
        for (ph = 0; ph < N_PHASES; ph++) begin
            settle();
            cv = (ph < 10) ? PHASE_CELLS[ph] : CFG_W'($urandom_range(0, 127));
            write_cells(cv);
            eff = (cv == 0) ? 1 : ((cv > MAX_CELLS) ? MAX_CELLS : cv);
            no_gaps = (ph == 3);
            if (ph == 5) squeeze = 1'b1;
            ws   = $urandom_range(1, eff + eff / 2 + 2);
            base = t_page'($urandom_range(0, 127));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(99);
                rs   = (roll < 3);
                if (roll >= 90) begin
                    pg = t_page'($urandom_range(0, 127));
                end else begin
                    pg = base + t_page'($urandom_range(0, ws - 1));
                end
                if ($urandom_range(49) == 0) base = t_page'($urandom_range(0, 127));
                offer_access(pg, rs, 1'b0, NO_TYPED);
            end
        end

        // With a single cell every new page faults and, after the first, evicts the page before it.
        settle();
        write_cells(7'd1);
        no_gaps = 1'b1;
        prev_pg = '0;
        for (k = 0; k < ONE_CELL_ITEMS; k++) begin
            pg = t_page'($urandom_range(0, 127));
            if (pg == prev_pg) pg = pg + 1'b1;
            prev_pg = pg;
            offer_access(pg, (k == 0), 1'b0, NO_TYPED);
        end

        in_ch.valid = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_err == 0) begin
            $display("tb_clock_page_replacement: clean");
        end else begin
            $display("tb_clock_page_replacement: errors");
        end
        $finish;
    end

endmodule
